// File: sv/msf_pkg.sv
// ----------------------------------------------------------------------------
// msf_pkg
// Shared constants, frame layout and controller/datapath command types for
// the message segment framer.
// ----------------------------------------------------------------------------
package msf_pkg;

  localparam int PAYLOAD_BYTES = 255;
  localparam int HEADER_BYTES  = 7;
  localparam int FRAME_BYTES   = PAYLOAD_BYTES + 9;
  localparam int FRAME_WORDS   = (FRAME_BYTES + 7) / 8;

  localparam int FILL_W     = $clog2(PAYLOAD_BYTES + 1);
  localparam int POS_W      = $clog2(FRAME_WORDS * 8);
  localparam int ROW_W      = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
  localparam int WORD_CNT_W = $clog2(FRAME_WORDS + 1);

  localparam logic [7:0] START_LO     = 8'hff;
  localparam logic [7:0] START_HI     = 8'hff;
  localparam logic [7:0] TYPE_LO      = 8'hf1;
  localparam logic [7:0] TYPE_HI      = 8'hff;
  localparam logic [7:0] END_LO       = 8'hff;
  localparam logic [7:0] END_HI       = 8'hff;
  localparam logic [7:0] CLIENT_RESET = 8'h45;

  // Fixed header byte positions inside a frame
  localparam int POS_START_LO = 0;
  localparam int POS_START_HI = 1;
  localparam int POS_CLIENT   = 2;
  localparam int POS_TYPE_LO  = 3;
  localparam int POS_TYPE_HI  = 4;
  localparam int POS_SEGNUM   = 5;
  localparam int POS_LENGTH   = 6;
  localparam int POS_END_LO   = HEADER_BYTES + PAYLOAD_BYTES;
  localparam int POS_END_HI   = HEADER_BYTES + PAYLOAD_BYTES + 1;

  typedef struct packed {
    logic             byte_wr;   // store the accepted byte
    logic             rd_issue;  // read one frame row
    logic [ROW_W-1:0] rd_row;    // row to read
    logic [ROW_W-1:0] s1_row;    // row held in the read register
    logic             out_load;  // load the output word register
    logic             out_last;  // word being loaded closes the frame
    logic             finish;    // frame fully composed, close the segment
    logic             msg_end;   // segment was the last of its message
  } msf_cmd_t;

  typedef struct packed {
    logic seg_full;  // next byte fills the segment
  } msf_status_t;

endpackage

// File: sv/msf_ctrl.sv
// ----------------------------------------------------------------------------
// msf_ctrl
// Controller: collect/emit state machine, frame row sequencing and the
// read and output register valid tracking.
// ----------------------------------------------------------------------------
module msf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  msf_pkg::msf_status_t status,
  output msf_pkg::msf_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_EMIT    = 2'b10
  } state_t;

  state_t                            state_r, state_nxt;
  logic [msf_pkg::WORD_CNT_W-1:0]    issue_cnt_r, issue_cnt_nxt;
  logic [msf_pkg::ROW_W-1:0]         s1_row_r, s1_row_nxt;
  logic                              s1_valid_r, s1_valid_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              last_r, last_nxt;
  logic                              in_acc;
  logic                              out_load;
  logic                              issue;
  logic                              s1_final;

  assign in_tready  = (state_r == ST_COLLECT);
  assign out_tvalid = out_valid_r;
  assign in_acc     = in_tvalid & in_tready;
  assign out_load   = s1_valid_r & (~out_valid_r | out_tready);
  assign issue      = (state_r == ST_EMIT)
                    & (issue_cnt_r < msf_pkg::WORD_CNT_W'(msf_pkg::FRAME_WORDS))
                    & (~s1_valid_r | out_load);
  assign s1_final   = (s1_row_r == msf_pkg::ROW_W'(msf_pkg::FRAME_WORDS - 1));

  always_comb begin
    state_nxt     = state_r;
    issue_cnt_nxt = issue_cnt_r;
    last_nxt      = last_r;
    s1_row_nxt    = issue ? msf_pkg::ROW_W'(issue_cnt_r) : s1_row_r;
    s1_valid_nxt  = issue ? 1'b1 : (out_load ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    if (issue) begin
      issue_cnt_nxt = issue_cnt_r + 1'b1;
    end
    case (state_r)
      ST_COLLECT: begin
        if (in_acc && (status.seg_full || in_tlast)) begin
          state_nxt     = ST_EMIT;
          issue_cnt_nxt = '0;
          last_nxt      = in_tlast;
        end
      end
      ST_EMIT: begin
        if (out_load && s1_final) begin
          state_nxt = ST_COLLECT;
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      issue_cnt_r <= '0;
      s1_row_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      s1_row_r    <= s1_row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
    end
  end

  always_comb begin
    cmd.byte_wr  = in_acc;
    cmd.rd_issue = issue;
    cmd.rd_row   = msf_pkg::ROW_W'(issue_cnt_r);
    cmd.s1_row   = s1_row_r;
    cmd.out_load = out_load;
    cmd.out_last = s1_final;
    cmd.finish   = out_load & s1_final & (state_r == ST_EMIT);
    cmd.msg_end  = last_r;
  end

endmodule

// File: sv/msf_dpath.sv
// ----------------------------------------------------------------------------
// msf_dpath
// Datapath: segment row memory, fill and segment counters, client id
// register, frame word composition and the output word register.
// ----------------------------------------------------------------------------
module msf_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           data_byte,
  input  logic                 cfg_wr,
  input  logic [7:0]           cfg_data,
  input  msf_pkg::msf_cmd_t    cmd,
  output msf_pkg::msf_status_t status,
  output logic [63:0]          frame_word,
  output logic                 frame_last
);

  // Payload byte i lives at frame position HEADER_BYTES + i, so a memory row
  // lines up with one outgoing frame word.
  logic [7:0][7:0]              mem_r [msf_pkg::FRAME_WORDS];
  logic [7:0][7:0]              rd_row_r;
  logic [msf_pkg::FILL_W-1:0]   fill_r;
  logic [7:0]                   seg_num_r;
  logic [7:0]                   client_r;
  logic [63:0]                  word_r;
  logic                         word_last_r;
  logic [msf_pkg::POS_W-1:0]    wr_pos;
  logic [msf_pkg::ROW_W-1:0]    wr_row;
  logic [2:0]                   wr_lane;
  logic [7:0][7:0]              word_nxt;

  assign wr_pos  = msf_pkg::POS_W'(fill_r) + msf_pkg::POS_W'(msf_pkg::HEADER_BYTES);
  assign wr_row  = msf_pkg::ROW_W'(wr_pos >> 3);
  assign wr_lane = wr_pos[2:0];

  assign status.seg_full = (fill_r == msf_pkg::FILL_W'(msf_pkg::PAYLOAD_BYTES - 1));

  always_ff @(posedge clk) begin
    if (cmd.byte_wr) begin
      mem_r[wr_row][wr_lane] <= data_byte;
    end
    if (cmd.rd_issue) begin
      rd_row_r <= mem_r[cmd.rd_row];
    end
  end

  // Build one frame word from the read row, header fields and markers.
  always_comb begin
    logic [msf_pkg::POS_W-1:0] pos;
    logic [msf_pkg::POS_W-1:0] pay_idx;
    for (int k = 0; k < 8; k++) begin
      pos     = msf_pkg::POS_W'({cmd.s1_row, 3'(k)});
      pay_idx = pos - msf_pkg::POS_W'(msf_pkg::HEADER_BYTES);
      if (pos == msf_pkg::POS_W'(msf_pkg::POS_START_LO)) begin
        word_nxt[k] = msf_pkg::START_LO;
      end else if (pos == msf_pkg::POS_W'(msf_pkg::POS_START_HI)) begin
        word_nxt[k] = msf_pkg::START_HI;
      end else if (pos == msf_pkg::POS_W'(msf_pkg::POS_CLIENT)) begin
        word_nxt[k] = client_r;
      end else if (pos == msf_pkg::POS_W'(msf_pkg::POS_TYPE_LO)) begin
        word_nxt[k] = msf_pkg::TYPE_LO;
      end else if (pos == msf_pkg::POS_W'(msf_pkg::POS_TYPE_HI)) begin
        word_nxt[k] = msf_pkg::TYPE_HI;
      end else if (pos == msf_pkg::POS_W'(msf_pkg::POS_SEGNUM)) begin
        word_nxt[k] = seg_num_r;
      end else if (pos == msf_pkg::POS_W'(msf_pkg::POS_LENGTH)) begin
        word_nxt[k] = 8'(fill_r);
      end else if (pos == msf_pkg::POS_W'(msf_pkg::POS_END_LO)) begin
        word_nxt[k] = msf_pkg::END_LO;
      end else if (pos == msf_pkg::POS_W'(msf_pkg::POS_END_HI)) begin
        word_nxt[k] = msf_pkg::END_HI;
      end else if (pay_idx < msf_pkg::POS_W'(fill_r)) begin
        // pos >= HEADER_BYTES here, so pay_idx did not wrap
        word_nxt[k] = rd_row_r[k];
      end else begin
        word_nxt[k] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      word_r      <= word_nxt;
      word_last_r <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      seg_num_r <= 8'd1;
      client_r  <= msf_pkg::CLIENT_RESET;
    end else begin
      if (cfg_wr) begin
        client_r <= cfg_data;
      end
      if (cmd.finish) begin
        fill_r    <= '0;
        seg_num_r <= cmd.msg_end ? 8'd1 : seg_num_r + 8'd1;
      end else if (cmd.byte_wr) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  assign frame_word = word_r;
  assign frame_last = word_last_r;

endmodule

// File: sv/message_segment_framer_unit.sv
// ----------------------------------------------------------------------------
// message_segment_framer_unit
// Gathers message bytes into 255-byte segments and sends each segment as a
// 264-byte frame of 33 little-endian 64-bit words.
// ----------------------------------------------------------------------------
// Message bytes arrive one beat at a time on the in_ channel, with in_tlast on
// the final byte of a message, and are taken at one byte per cycle. When a
// segment fills (255 bytes) or the final byte arrives, input stalls while the
// frame goes out: 33 beats on out_, paced by the single read port of the
// segment memory and the output word register. Each frame carries start
// marker 0xffff, the client id, data type 0xfff1, the segment number (1
// first, wrapping through 0 after 255), the payload length, 255 payload
// bytes with unused ones zero, and end marker 0xffff; the earliest byte sits
// in bits 7:0 of each word, and out_tlast marks the last word. After a
// message's final frame the segment number goes back to 1. The client id is
// written through the cfg_ port (reset 0x45); the user must write it only
// while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module message_segment_framer_unit (
  input  logic        clk,
  input  logic        rst_n,
  // message byte channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  // frame word channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] frame_word
  output logic        out_tlast,  // frame_last
  // client id register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  msf_pkg::msf_cmd_t    cmd;
  msf_pkg::msf_status_t status;

  // Config writes are for the user to make only while idle; the block does not enforce this and always takes them.
  assign cfg_ready = 1'b1;

  msf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  msf_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .data_byte  (in_tdata),
    .cfg_wr     (cfg_valid & cfg_ready),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .frame_word (out_tdata),
    .frame_last (out_tlast)
  );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for message_segment_framer_unit: drives message bytes
// with random gaps and receiver stalls, predicts every 64-bit frame word from
// its own copy of the framer state, and compares each word as it leaves.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          CLK_HALF      = 6;
  localparam int          RESET_CYCLES  = 10;
  // Quiet time after the last expected frame word: slack for two frames.
  localparam int          DRAIN_CYCLES  = 70;
  localparam int          RX_HOLD_CYCLES = 400;
  localparam int          RANDOM_BYTES  = 140;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  typedef struct {
    logic [63:0] word;
    logic        closes;
  } frame_beat_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data   = 8'h00;

  // Shared knobs: no_idle removes gaps on both sides, rx_hold_req asks the
  // frame sink for one long hold-off.
  bit          no_idle     = 1'b0;
  bit          rx_hold_req = 1'b0;

  // Framer state as the bench sees it.
  logic [7:0]  seg_bytes [msf_pkg::PAYLOAD_BYTES];
  logic [7:0]  seg_fill        = 8'd0;
  logic [7:0]  seg_num         = 8'd1;
  logic [7:0]  client_id_model = msf_pkg::CLIENT_RESET;

  frame_beat_t frame_words_due [$];
  int unsigned bytes_sent  = 0;
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;

  message_segment_framer_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Watchdog: end the run if traffic never drains.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Gap length in cycles: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Take one accepted byte into the segment; on a full segment or the final
  // byte of a message, queue the 33 words of the frame it closes.
  function automatic void absorb_byte(input logic [7:0] b, input logic closes_msg);
    logic [7:0]  frame [msf_pkg::FRAME_WORDS * 8];
    frame_beat_t beat;
    seg_bytes[seg_fill] = b;
    seg_fill++;
    if (seg_fill != msf_pkg::PAYLOAD_BYTES && !closes_msg) return;

    // Unused payload bytes and any tail past the frame stay zero.
    foreach (frame[i]) frame[i] = 8'h00;
    frame[msf_pkg::POS_START_LO] = msf_pkg::START_LO;
    frame[msf_pkg::POS_START_HI] = msf_pkg::START_HI;
    frame[msf_pkg::POS_CLIENT]   = client_id_model;
    frame[msf_pkg::POS_TYPE_LO]  = msf_pkg::TYPE_LO;
    frame[msf_pkg::POS_TYPE_HI]  = msf_pkg::TYPE_HI;
    frame[msf_pkg::POS_SEGNUM]   = seg_num;
    frame[msf_pkg::POS_LENGTH]   = seg_fill;
    for (int i = 0; i < seg_fill; i++) frame[msf_pkg::HEADER_BYTES + i] = seg_bytes[i];
    frame[msf_pkg::POS_END_LO]   = msf_pkg::END_LO;
    frame[msf_pkg::POS_END_HI]   = msf_pkg::END_HI;

    // Pack little-endian: earliest byte in bits 7:0.
    for (int w = 0; w < msf_pkg::FRAME_WORDS; w++) begin
      for (int k = 0; k < 8; k++) beat.word[8*k +: 8] = frame[8*w + k];
      beat.closes = (w == msf_pkg::FRAME_WORDS - 1);
      frame_words_due.push_back(beat);
    end

    seg_fill = 8'd0;
    // A message end restarts numbering; otherwise advance and wrap at 8 bits.
    seg_num  = closes_msg ? 8'd1 : seg_num + 8'd1;
  endfunction

  function automatic void report_mismatch(input string field, input logic [63:0] exp_v,
                                          input logic [63:0] got_v);
    mismatches++;
    $error("%s: expected %h, got %h", field, exp_v, got_v);
  endfunction

  // Offer one byte after a random gap and hold it until the framer takes it.
  // Valid stays high between back-to-back beats.
  task automatic send_byte(input logic [7:0] b, input logic closes_msg);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= closes_msg;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    absorb_byte(b, closes_msg);
    bytes_sent++;
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // Drop valid, wait for every queued frame word, then let the block go quiet.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (frame_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the client id; call only while the framer is idle.
  task automatic write_client_id(input logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    client_id_model = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Frame sink: random ready pattern, plus one long hold-off on request.
  initial begin : frame_sink
    int unsigned stall;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall = RX_HOLD_CYCLES;
      end else begin
        stall = pick_gap();
      end
      if (stall == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  // Compare every accepted frame beat with the oldest queued word.
  always @(posedge clk) begin : frame_check
    frame_beat_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_words_due.size() == 0) begin
        mismatches++;
        $error("frame_word %h arrived with no frame word expected", out_tdata);
      end else begin
        due = frame_words_due.pop_front();
        if (out_tdata !== due.word) report_mismatch("frame_word", due.word, out_tdata);
        if (out_tlast !== due.closes)
          report_mismatch("frame_last", 64'(due.closes), 64'(out_tlast));
      end
    end
  end

  // Reset client id, single-byte and short messages, zero bytes taken as data.
  task automatic test_header_defaults();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    settle();
  endtask

  // Client id at both ends of its range.
  task automatic test_client_id_extremes();
    write_client_id(8'h00);
    send_message(3);
    settle();
    write_client_id(8'hff);
    send_message(1);
    settle();
  endtask

  // One byte over a segment: a full frame mid-message, segment number 2 on
  // the one-byte tail frame, and numbering back at 1 for the next message.
  task automatic test_segment_boundaries();
    write_client_id(8'h3c);
    send_message(msf_pkg::PAYLOAD_BYTES + 1);
    send_message(2);
    settle();
  endtask

  // Hold the sink off while short messages keep coming, so a frame backs up
  // in the block and input stalls until the sink lets the frame out.
  task automatic test_output_backpressure();
    no_idle = 1'b1;
    rx_hold_req = 1'b1;
    send_message(4);
    send_message(4);
    send_message(4);
    settle();
    no_idle = 1'b0;
  endtask

  // Mostly very short messages, some longer ones; client id rewritten now
  // and then while idle.
  task automatic test_random_traffic();
    int unsigned first_byte;
    int unsigned msgs;
    int unsigned r;
    first_byte = bytes_sent;
    msgs = 0;
    while (bytes_sent - first_byte < RANDOM_BYTES) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if (msgs % 8 == 0) begin
        settle();
        write_client_id(8'($urandom_range(0, 255)));
      end
      r = $urandom_range(0, 99);
      if (r < 80) send_message($urandom_range(1, 8));
      else        send_message($urandom_range(9, 24));
      msgs++;
    end
    no_idle = 1'b0;
    settle();
  endtask

  initial begin : run
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_header_defaults();
    test_client_id_extremes();
    test_segment_boundaries();
    test_output_backpressure();
    test_random_traffic();

    if (frame_words_due.size() != 0) begin
      mismatches++;
      $error("%0d frame words never arrived", frame_words_due.size());
    end
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
